// ===== hdl/rme_pkg.sv =====
package rme_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W = $clog2(CAPACITY + 1);
   localparam int DATA_W = 32;
   localparam int MID_POS = (CAPACITY - 1) / 2;
   localparam logic [IDX_W-1:0] MID_INDEX = IDX_W'(MID_POS);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_TAKE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT_UP,
      OP_INSERT_DOWN,
      OP_TAKE_UP,
      OP_TAKE_DOWN
   } op_type;

   typedef struct packed {
      op_type op;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      logic [IDX_W-1:0] slot;
   } cell_ctl_type;

   typedef struct packed {
      logic gt;
      logic le;
   } cell_flags_type;

endpackage

// ===== hdl/rme_if.sv =====
interface rme_req_if;
   import rme_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic signed [DATA_W-1:0] value;
   modport source(output valid, command, value, input ready);
   modport sink(input valid, command, value, output ready);
endinterface

interface rme_rsp_if;
   import rme_pkg::*;
   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] median;
   logic [1:0] status;
   modport source(output valid, median, status, input ready);
   modport sink(input valid, median, status, output ready);
endinterface

// ===== hdl/running_median_extract.sv =====
// A take or a full insert shows its result in the cycle after acceptance. Each
// cell compares and shifts at once; one transaction per cycle unless a result stalls.
// The lower median always sits in the center cell, so it is read at a fixed place.
// Reset (synchronous, active high) empties the store and drops a pending result;
// cell contents are left as they are and are never read before being written.
module running_median_extract (
   input logic    clock,
   input logic    reset,
   rme_req_if.sink   req_chan,
   rme_rsp_if.source rsp_chan
);
   import rme_pkg::*;

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_median_ff;
   logic signed [DATA_W-1:0] rsp_median_in;
   logic [1:0] rsp_status_ff;
   logic [1:0] rsp_status_in;

   logic accept;
   logic has_result;
   logic signed [DATA_W-1:0] result_median;
   logic [1:0] result_status;
   logic [IDX_W:0] half_up;
   logic [IDX_W-1:0] lo;
   logic [IDX_W-1:0] hi;
   cell_ctl_type cell_ctl;

   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   cell_flags_type cell_flags [CAPACITY];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign half_up = ({1'b0, count_ff} + 1'b1) >> 1;
   assign lo = IDX_W'(MID_POS + 1) - half_up[IDX_W-1:0];
   assign hi = MID_INDEX + (count_ff >> 1);

   always_comb begin
      cell_ctl.op = OP_HOLD;
      cell_ctl.value = req_chan.value;
      cell_ctl.lo = lo;
      cell_ctl.hi = hi;
      cell_ctl.slot = count_ff[0] ? (hi + 1'b1) : (lo - 1'b1);
      count_in = count_ff;
      has_result = 1'b0;
      result_median = '0;
      result_status = ST_OK;
      if (accept) begin
         unique case (req_chan.command)
            CMD_INSERT: begin
               if (count_ff == IDX_W'(CAPACITY)) begin
                  has_result = 1'b1;
                  result_status = ST_FULL;
               end else begin
                  cell_ctl.op = count_ff[0] ? OP_INSERT_UP : OP_INSERT_DOWN;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_TAKE: begin
               has_result = 1'b1;
               if (count_ff == '0) begin
                  result_status = ST_EMPTY;
               end else begin
                  cell_ctl.op = count_ff[0] ? OP_TAKE_UP : OP_TAKE_DOWN;
                  result_median = cell_data[MID_POS];
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_median_in = rsp_median_ff;
      rsp_status_in = rsp_status_ff;
      if (has_result) begin
         rsp_valid_in = 1'b1;
         rsp_median_in = result_median;
         rsp_status_in = result_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.median = rsp_median_ff;
   assign rsp_chan.status = rsp_status_ff;

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;
      cell_flags_type left_flags;
      cell_flags_type right_flags;

      if (j == 0) begin : g_first
         assign left_data = '0;
         assign left_flags = '0;
      end else begin : g_left
         assign left_data = cell_data[j-1];
         assign left_flags = cell_flags[j-1];
      end

      if (j == CAPACITY - 1) begin : g_last
         assign right_data = '0;
         assign right_flags = '0;
      end else begin : g_right
         assign right_data = cell_data[j+1];
         assign right_flags = cell_flags[j+1];
      end

      rme_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .cell_index  (IDX_W'(j)),
         .left_data   (left_data),
         .left_flags  (left_flags),
         .right_data  (right_data),
         .right_flags (right_flags),
         .data_out    (cell_data[j]),
         .flags_out   (cell_flags[j])
      );
   end

endmodule

// ===== hdl/rme_cell.sv =====
module rme_cell (
   input  logic                                  clock,
   input  rme_pkg::cell_ctl_type                 ctl,
   input  logic [rme_pkg::IDX_W-1:0]             cell_index,
   input  logic signed [rme_pkg::DATA_W-1:0]     left_data,
   input  rme_pkg::cell_flags_type               left_flags,
   input  logic signed [rme_pkg::DATA_W-1:0]     right_data,
   input  rme_pkg::cell_flags_type               right_flags,
   output logic signed [rme_pkg::DATA_W-1:0]     data_out,
   output rme_pkg::cell_flags_type               flags_out
);
   import rme_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic in_range;
   logic above;

   assign in_range = (cell_index >= ctl.lo) && (cell_index <= ctl.hi);
   assign above = data_ff > ctl.value;
   assign flags_out.gt = in_range && above;
   assign flags_out.le = in_range && !above;
   assign data_out = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_INSERT_UP: begin
            if (left_flags.gt) begin
               data_in = left_data;
            end else if (flags_out.gt || (cell_index == ctl.slot)) begin
               data_in = ctl.value;
            end
         end
         OP_INSERT_DOWN: begin
            if (right_flags.le) begin
               data_in = right_data;
            end else if (flags_out.le || (cell_index == ctl.slot)) begin
               data_in = ctl.value;
            end
         end
         OP_TAKE_UP: begin
            if ((cell_index > ctl.lo) && (cell_index <= MID_INDEX)) begin
               data_in = left_data;
            end
         end
         OP_TAKE_DOWN: begin
            if ((cell_index >= MID_INDEX) && (cell_index < ctl.hi)) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import rme_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] median;
      logic [1:0] status;
   } median_rsp_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic signed [DATA_W-1:0] value;
      logic typed_in;
      logic signed [DATA_W-1:0] median;
      logic [1:0] status;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam int PHASE_ITEMS = 110;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset;

   rme_req_if req_if ();
   rme_rsp_if rsp_if ();

   running_median_extract DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   always #5 clock = ~clock;

   logic signed [DATA_W-1:0] sorted_copy [CAPACITY];
   int sorted_count = 0;
   median_rsp_type pending_medians [$];
   int fail_count = 0;
   int accepted_items = 0;
   int send_idle = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   directed_row_type directed_rows [DIRECTED_ROWS];

   function automatic void track_sorted_store(input logic [1:0] cmd,
                                              input logic signed [DATA_W-1:0] val,
                                              output bit has_rsp,
                                              output median_rsp_type rsp);
      int pos;
      int mid;
      has_rsp = 1'b0;
      rsp = '0;
      case (cmd)
         CMD_INSERT: begin
            if (sorted_count >= CAPACITY) begin
               has_rsp = 1'b1;
               rsp.status = ST_FULL;
            end else begin
               pos = sorted_count;
               while (pos > 0 && sorted_copy[pos-1] > val) begin
                  sorted_copy[pos] = sorted_copy[pos-1];
                  pos--;
               end
               sorted_copy[pos] = val;
               sorted_count++;
            end
         end
         CMD_TAKE: begin
            has_rsp = 1'b1;
            if (sorted_count == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               mid = (sorted_count - 1) / 2;
               rsp.median = sorted_copy[mid];
               rsp.status = ST_OK;
               for (int i = mid; i + 1 < sorted_count; i++)
                  sorted_copy[i] = sorted_copy[i+1];
               sorted_count--;
            end
         end
         CMD_CLEAR: sorted_count = 0;
         default: ;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      int near_zero;
      near_zero = $urandom_range(8);
      case ($urandom_range(5))
         0: return near_zero - 4;
         1: return near_zero - 4;
         2: return $urandom_range(1) ? VAL_MIN : VAL_MAX;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
                            input bit typed_in, input median_rsp_type typed_rsp);
      bit has_rsp;
      median_rsp_type rsp;
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.value <= val;
      do @(posedge clock); while (!req_if.ready);
      track_sorted_store(cmd, val, has_rsp, rsp);
      if (typed_in)
         pending_medians.push_back(typed_rsp);
      else if (has_rsp)
         pending_medians.push_back(rsp);
      if (cmd != CMD_UNUSED)
         accepted_items++;
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_medians.size() != 0);
   endtask

   task automatic run_case(input int n_ops, input int take_pct, input bit open_clear);
      int r;
      if (open_clear)
         send_item(CMD_CLEAR, $urandom, 1'b0, '0);
      repeat (n_ops) begin
         r = $urandom_range(99);
         if (r < 2)
            send_item(CMD_UNUSED, $urandom, 1'b0, '0);
         else if (r < 3)
            send_item(CMD_CLEAR, $urandom, 1'b0, '0);
         else if (r < 3 + take_pct)
            send_item(CMD_TAKE, $urandom, 1'b0, '0);
         else
            send_item(CMD_INSERT, rand_value(), 1'b0, '0);
      end
   endtask

   task automatic fill_and_empty();
      send_item(CMD_CLEAR, '0, 1'b0, '0);
      repeat (CAPACITY + 3)
         send_item(CMD_INSERT, rand_value(), 1'b0, '0);
      repeat (CAPACITY + 2)
         send_item(CMD_TAKE, $urandom, 1'b0, '0);
   endtask

   always @(posedge clock)
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_rsp
      median_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_medians.size() == 0) begin
            $error("unexpected result: median %0d status %0d", rsp_if.median, rsp_if.status);
            fail_count++;
         end else begin
            want = pending_medians.pop_front();
            if (rsp_if.median !== want.median) begin
               $error("median mismatch: expected %0d, actual %0d", want.median, rsp_if.median);
               fail_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_if.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      median_rsp_type typed_rsp;
      int phase_start;
      directed_rows = '{
         '{CMD_TAKE, 32'sd0, 1'b1, 32'sd0, ST_EMPTY},
         '{CMD_INSERT, VAL_MIN, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, VAL_MAX, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b1, VAL_MIN, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b1, VAL_MAX, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b1, 32'sd0, ST_EMPTY},
         '{CMD_INSERT, 32'sd0, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, -32'sd1, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, 32'sd1, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b1, 32'sd0, ST_OK},
         '{CMD_UNUSED, 32'h5555_AAAA, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, 32'sd7, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, 32'sd7, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, 32'sd7, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b0, 32'sd0, ST_OK},
         '{CMD_CLEAR, VAL_MAX, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, 32'sd0, 1'b1, 32'sd0, ST_EMPTY},
         '{CMD_INSERT, 32'h7FFF_FFFE, 1'b0, 32'sd0, ST_OK},
         '{CMD_INSERT, 32'h8000_0001, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, 32'h0F0F_F0F0, 1'b0, 32'sd0, ST_OK},
         '{CMD_CLEAR, 32'sd0, 1'b0, 32'sd0, ST_OK},
         '{CMD_TAKE, -32'sd1, 1'b1, 32'sd0, ST_EMPTY}
      };
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.command <= CMD_INSERT;
      req_if.value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         typed_rsp.median = row.median;
         typed_rsp.status = row.status;
         send_item(row.cmd, row.value, row.typed_in, typed_rsp);
      end
      wait_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0; stall_pct <= 0; end
            1: begin send_idle = 85; stall_pct <= 0; end
            2: begin send_idle = 0; stall_pct <= 85; end
            default: begin send_idle = 17; stall_pct <= 17; end
         endcase
         if (phase == 0)
            fill_and_empty();
         phase_start = accepted_items;
         while (accepted_items - phase_start < PHASE_ITEMS)
            run_case($urandom_range(1, 40), $urandom_range(20, 60), $urandom_range(9) != 0);
         wait_drain();
      end

      send_idle = 0;
      stall_pct <= 0;
      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rme_pkg.sv
hdl/rme_if.sv
hdl/rme_cell.sv
hdl/running_median_extract.sv
tb/sv/tb.sv
